@@ rtl/hvsc_pkg.sv @@
// Shared types, character codes and the void element table for the HTML self-closer.
package hvsc_pkg;

    localparam int NAME_LIMIT = 32;
    localparam int NAME_STORE = 6;
    localparam int VOID_COUNT = 14;
    localparam int LEN_W      = $clog2(NAME_LIMIT);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [LEN_W-1:0] name_len_t;
    typedef logic [NAME_STORE-1:0][7:0] name_store_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // What the scanner hands to the output buffer for one accepted request.
    typedef struct packed {
        logic       two;
        logic [7:0] data_byte;
    } emit_t;

    // Names are left aligned: the first character sits in the top byte.
    localparam logic [8*NAME_STORE-1:0] VOID_NAME [VOID_COUNT] = '{
        {"area",   16'h0}, {"base", 16'h0}, {"br",   32'h0}, {"col",   24'h0},
        {"embed",   8'h0}, {"hr",   32'h0}, {"img",  24'h0}, {"input",  8'h0},
        {"link",   16'h0}, {"meta", 16'h0}, {"param", 8'h0}, {"source"},
        {"track",   8'h0}, {"wbr",  24'h0}
    };

    localparam int VOID_LEN [VOID_COUNT] = '{4, 4, 2, 3, 5, 2, 3, 5, 4, 4, 5, 6, 5, 3};

    function automatic logic name_is_void(input name_store_t chars, input name_len_t len);
        logic hit;
        logic same;
        hit = 1'b0;
        for (int i = 0; i < VOID_COUNT; i++) begin
            same = (len == LEN_W'(VOID_LEN[i]));
            for (int k = 0; k < NAME_STORE; k++) begin
                if (k < VOID_LEN[i] &&
                    chars[k] != VOID_NAME[i][8*(NAME_STORE-k)-1 -: 8]) begin
                    same = 1'b0;
                end
            end
            hit = hit | same;
        end
        return hit;
    endfunction

endpackage

@@ rtl/hvsc_scanner.sv @@
// Tag scanner: tracks tag state, gathers the name and decides on slash insertion.
module hvsc_scanner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  hvsc_pkg::in_item_t item,
    output hvsc_pkg::emit_t   emit
);

    logic                  inside_tag_reg, inside_tag_next;
    hvsc_pkg::name_store_t name_chars_reg, name_chars_next;
    hvsc_pkg::name_len_t   name_length_reg, name_length_next;
    logic                  gathering_name_reg, gathering_name_next;
    logic                  closing_tag_reg, closing_tag_next;
    logic                  tag_is_void_reg, tag_is_void_next;
    logic                  declaration_tag_reg, declaration_tag_next;
    logic [7:0]            previous_byte_reg, previous_byte_next;

    logic       in_tag;
    logic [7:0] b;
    logic [7:0] lower;
    logic       finishing;
    logic       void_final;
    logic       is_space;

    assign b      = item.in_byte;
    assign in_tag = inside_tag_reg & ~item.file_start;
    assign lower  = (b >= hvsc_pkg::CH_UP_A && b <= hvsc_pkg::CH_UP_Z) ?
                    b + hvsc_pkg::CASE_OFS : b;
    assign is_space = (b == hvsc_pkg::CH_SPACE) || (b == hvsc_pkg::CH_TAB) ||
                      (b == hvsc_pkg::CH_CR) || (b == hvsc_pkg::CH_LF);

    // A name that ends now decides the void flag, unless it belongs to a closing tag.
    assign finishing  = gathering_name_reg && (name_length_reg != '0);
    assign void_final = (finishing && !closing_tag_reg) ?
                        hvsc_pkg::name_is_void(name_chars_reg, name_length_reg) :
                        tag_is_void_reg;

    always_comb begin
        inside_tag_next      = inside_tag_reg;
        name_chars_next      = name_chars_reg;
        name_length_next     = name_length_reg;
        gathering_name_next  = gathering_name_reg;
        closing_tag_next     = closing_tag_reg;
        tag_is_void_next     = tag_is_void_reg;
        declaration_tag_next = declaration_tag_reg;
        previous_byte_next   = previous_byte_reg;
        emit.two             = 1'b0;
        emit.data_byte       = b;

        if (!in_tag) begin
            inside_tag_next = 1'b0;
            if (b == hvsc_pkg::CH_LT) begin
                inside_tag_next      = 1'b1;
                name_length_next     = '0;
                gathering_name_next  = 1'b1;
                closing_tag_next     = 1'b0;
                tag_is_void_next     = 1'b0;
                declaration_tag_next = 1'b0;
                previous_byte_next   = hvsc_pkg::CH_LT;
            end
        end else if (b == hvsc_pkg::CH_GT) begin
            inside_tag_next  = 1'b0;
            tag_is_void_next = void_final;
            if (finishing) begin
                gathering_name_next = 1'b0;
            end
            emit.two = !declaration_tag_reg && void_final &&
                       (previous_byte_reg != hvsc_pkg::CH_SLASH);
        end else begin
            previous_byte_next = b;
            if (gathering_name_reg) begin
                if (name_length_reg == '0 && b == hvsc_pkg::CH_SLASH) begin
                    closing_tag_next = 1'b1;
                end else if (name_length_reg == '0 &&
                             (b == hvsc_pkg::CH_BANG || b == hvsc_pkg::CH_QUEST)) begin
                    declaration_tag_next = 1'b1;
                    gathering_name_next  = 1'b0;
                end else if (is_space || b == hvsc_pkg::CH_SLASH) begin
                    tag_is_void_next = void_final;
                    if (finishing) begin
                        gathering_name_next = 1'b0;
                    end
                end else if (name_length_reg <
                             hvsc_pkg::LEN_W'(hvsc_pkg::NAME_LIMIT - 1)) begin
                    if (name_length_reg < hvsc_pkg::LEN_W'(hvsc_pkg::NAME_STORE)) begin
                        name_chars_next[name_length_reg[2:0]] = lower;
                    end
                    name_length_next = name_length_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tag_reg      <= 1'b0;
            name_length_reg     <= '0;
            gathering_name_reg  <= 1'b0;
            closing_tag_reg     <= 1'b0;
            tag_is_void_reg     <= 1'b0;
            declaration_tag_reg <= 1'b0;
            previous_byte_reg   <= '0;
        end else if (accept) begin
            inside_tag_reg      <= inside_tag_next;
            name_length_reg     <= name_length_next;
            gathering_name_reg  <= gathering_name_next;
            closing_tag_reg     <= closing_tag_next;
            tag_is_void_reg     <= tag_is_void_next;
            declaration_tag_reg <= declaration_tag_next;
            previous_byte_reg   <= previous_byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            name_chars_reg <= name_chars_next;
        end
    end

endmodule

@@ rtl/hvsc_out_buf.sv @@
// Two-entry result buffer that turns one request into one or two output bytes.
module hvsc_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hvsc_pkg::emit_t     emit,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output hvsc_pkg::out_item_t m_data
);

    hvsc_pkg::out_item_t slot0_reg, slot0_next;
    hvsc_pkg::out_item_t slot1_reg, slot1_next;
    logic [1:0]          count_reg, count_next;
    logic                pop;

    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = slot0_reg;
    assign pop      = m_valid && m_ready;
    // The buffer must be empty once this cycle's pop has gone.
    assign can_push = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push) begin
            if (emit.two) begin
                slot0_next = '{out_byte: hvsc_pkg::CH_SLASH, last_of_run: 1'b0};
                slot1_next = '{out_byte: hvsc_pkg::CH_GT, last_of_run: 1'b1};
                count_next = 2'd2;
            end else begin
                slot0_next = '{out_byte: emit.data_byte, last_of_run: 1'b1};
                count_next = 2'd1;
            end
        end else if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/html_void_element_self_closer.sv @@
// HTML void element self-closer: echoes bytes and adds '/' before '>' of void opening tags.
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while m_ready stays high; a '>' that gets an inserted '/' yields two
// results and holds s_ready low while both are buffered, until the first has been taken.
// Reset: synchronous active-low aresetn clears the tag state and empties the buffer;
// the stored name characters are not reset.
module html_void_element_self_closer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hvsc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hvsc_pkg::out_item_t m_data
);

    hvsc_pkg::emit_t emit;
    logic            can_push;
    logic            accept;

    assign s_ready = can_push;
    assign accept  = s_valid && can_push;

    hvsc_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .emit    (emit)
    );

    hvsc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .emit     (emit),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
